// ----- hw/rtl/c2p_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// c2p_pkg
// Types and constants shared by the conserved-to-primitive MHD converter.
// ----------------------------------------------------------------------------
package c2p_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int WORD_BITS  = 32;
    localparam int GAMMA_BITS = 19;
    localparam logic [GAMMA_BITS-1:0] GAMMA_RESET = 19'd109227;

    // pipelined divider: 48 quotient bits, 4 per stage
    localparam int NUM_BITS   = 64;
    localparam int DEN_BITS   = 33;
    localparam int REM_BITS   = DEN_BITS + 1;
    localparam int QUO_BITS   = 48;
    localparam int DIV_STEP   = 4;
    localparam int DIV_STAGES = QUO_BITS / DIV_STEP;

    typedef enum logic [0:0] {
        CFG_GAMMA_Q  = 1'b0,
        CFG_MHD_MODE = 1'b1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_NEG_PRESSURE = 2'd1,
        ST_BAD_DENSITY  = 2'd2
    } status_t;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] cons_density;
        logic signed [WORD_BITS-1:0] cons_mom_x;
        logic signed [WORD_BITS-1:0] cons_mom_y;
        logic signed [WORD_BITS-1:0] cons_mom_z;
        logic signed [WORD_BITS-1:0] cons_energy;
        logic signed [WORD_BITS-1:0] cons_bx;
        logic signed [WORD_BITS-1:0] cons_by;
        logic signed [WORD_BITS-1:0] cons_bz;
        logic                        is_interior;
    } cons_t;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] prim_density;
        logic signed [WORD_BITS-1:0] prim_vel_x;
        logic signed [WORD_BITS-1:0] prim_vel_y;
        logic signed [WORD_BITS-1:0] prim_vel_z;
        logic signed [WORD_BITS-1:0] prim_pressure;
        logic signed [WORD_BITS-1:0] prim_bx;
        logic signed [WORD_BITS-1:0] prim_by;
        logic signed [WORD_BITS-1:0] prim_bz;
        status_t                     status;
    } prim_t;

    // per-cell data riding alongside the dividers
    typedef struct packed {
        logic signed [WORD_BITS-1:0] rho;
        logic                        rho_pos;
        logic signed [WORD_BITS-1:0] energy;
        logic signed [WORD_BITS-1:0] bx;
        logic signed [WORD_BITS-1:0] by;
        logic signed [WORD_BITS-1:0] bz;
        logic [2:0]                  mom_neg;
        logic [2:0]                  mom_nz;
        logic                        interior;
        logic [QUO_BITS-1:0]         mag_e;
    } side_t;

endpackage : c2p_pkg
`default_nettype wire

// ----- hw/rtl/c2p_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// c2p_cons_if / c2p_prim_if
// Valid/ready channels carrying one cell word each.
// ----------------------------------------------------------------------------
interface c2p_cons_if
    import c2p_pkg::*;
();
    logic  valid;
    logic  ready;
    cons_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface : c2p_cons_if

interface c2p_prim_if
    import c2p_pkg::*;
();
    logic  valid;
    logic  ready;
    prim_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface : c2p_prim_if
`default_nettype wire

// ----- hw/rtl/c2p_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// c2p_div
// Pipelined restoring divider: 48 quotient bits, four per stage.
// ----------------------------------------------------------------------------
module c2p_div
    import c2p_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                en,
    input  wire logic [NUM_BITS-1:0] num,
    input  wire logic [DEN_BITS-1:0] den,
    output logic      [QUO_BITS-1:0] quo,
    output logic                     ovf
);

    logic [REM_BITS-1:0] r_reg [DIV_STAGES];
    logic [QUO_BITS-1:0] n_reg [DIV_STAGES];
    logic [QUO_BITS-1:0] q_reg [DIV_STAGES];
    logic [DEN_BITS-1:0] d_reg [DIV_STAGES];
    logic                o_reg [DIV_STAGES];

    logic [REM_BITS-1:0] r_next [DIV_STAGES];
    logic [QUO_BITS-1:0] n_next [DIV_STAGES];
    logic [QUO_BITS-1:0] q_next [DIV_STAGES];
    logic [DEN_BITS-1:0] d_next [DIV_STAGES];
    logic                o_next [DIV_STAGES];

    always_comb
    begin
        logic [REM_BITS-1:0] r;
        logic [QUO_BITS-1:0] n;
        logic [QUO_BITS-1:0] q;
        logic [DEN_BITS-1:0] d;
        logic                o;
        logic                ge;
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            if (s == 0)
            begin
                // upper part seeds the remainder; overflow if it is not below den
                r = REM_BITS'(num[NUM_BITS-1:QUO_BITS]);
                n = num[QUO_BITS-1:0];
                q = '0;
                d = den;
                o = (DEN_BITS'(num[NUM_BITS-1:QUO_BITS]) >= den);
            end
            else
            begin
                r = r_reg[s-1];
                n = n_reg[s-1];
                q = q_reg[s-1];
                d = d_reg[s-1];
                o = o_reg[s-1];
            end
            for (int k = 0; k < DIV_STEP; k++)
            begin
                r  = {r[REM_BITS-2:0], n[QUO_BITS-1]};
                n  = {n[QUO_BITS-2:0], 1'b0};
                ge = (r >= REM_BITS'(d));
                if (ge)
                begin
                    r = r - REM_BITS'(d);
                end
                q = {q[QUO_BITS-2:0], ge};
            end
            r_next[s] = r;
            n_next[s] = n;
            q_next[s] = q;
            d_next[s] = d;
            o_next[s] = o;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < DIV_STAGES; s++)
            begin
                r_reg[s] <= r_next[s];
                n_reg[s] <= n_next[s];
                q_reg[s] <= q_next[s];
                d_reg[s] <= d_next[s];
                o_reg[s] <= o_next[s];
            end
        end
    end

    assign quo = q_reg[DIV_STAGES-1];
    assign ovf = o_reg[DIV_STAGES-1];

endmodule : c2p_div
`default_nettype wire

// ----- hw/rtl/conserved_to_primitive_mhd.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// conserved_to_primitive_mhd
// One MHD cell per word: conserved state in, primitive state out.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle unless the output stalls; the 48-bit quotients
//   come from divider pipelines of 12 stages, four quotient bits a stage.
// A stall at the output freezes the whole pipeline; nothing is dropped.
// Reset (rst_n low, async) empties the pipeline and sets gamma_q to
//   109227 (5/3 in Q3.16) and MHD mode on.
// ----------------------------------------------------------------------------
module conserved_to_primitive_mhd
    import c2p_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire cfg_idx_t              cfg_index,
    input  wire logic [GAMMA_BITS-1:0] cfg_data,
    c2p_cons_if.sink                   cons,
    c2p_prim_if.source                 prim
);

    localparam int SIDE_STAGES = 3 + DIV_STAGES;   // input, square, sum, divide
    localparam int NSTAGE      = SIDE_STAGES + 3;  // + inner, product, output
    localparam logic signed [WORD_BITS-1:0] WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic signed [WORD_BITS-1:0] WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam int INNER_BITS = 52;
    localparam int PRODH      = 24;
    localparam int PROD_BITS  = QUO_BITS + GAMMA_BITS;

    // ---------------- configuration ----------------
    logic [GAMMA_BITS-1:0] gamma_q_reg;
    logic                  mhd_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gamma_q_reg  <= GAMMA_RESET;
            mhd_mode_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_GAMMA_Q:  gamma_q_reg  <= cfg_data;
                CFG_MHD_MODE: mhd_mode_reg <= cfg_data[0];
                default:      ;
            endcase
        end
    end

    // ---------------- flow control ----------------
    // single enable: everything moves unless the output word is held
    logic              en;
    logic [NSTAGE-1:0] vld_reg;

    assign en         = !vld_reg[NSTAGE-1] || prim.ready;
    assign cons.ready = en;
    assign prim.valid = vld_reg[NSTAGE-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NSTAGE-2:0], cons.valid};
        end
    end

    function automatic logic [WORD_BITS-1:0] mag_word(input logic signed [WORD_BITS-1:0] v);
        mag_word = v[WORD_BITS-1] ? WORD_BITS'(-v) : WORD_BITS'(v);
    endfunction

    // saturate a sign/magnitude pair to the word range
    function automatic logic signed [WORD_BITS-1:0] sat_word(input logic neg,
                                                              input logic [50:0] m);
        if (neg)
        begin
            sat_word = (m >= 51'(WMAX) + 51'd1) ? WMIN : $signed(WORD_BITS'(0) - m[31:0]);
        end
        else
        begin
            sat_word = (m > 51'(WMAX)) ? WMAX : $signed(m[31:0]);
        end
    endfunction

    // ---------------- stage 0: unpack, magnitudes ----------------
    side_t               side_reg [SIDE_STAGES];
    logic [WORD_BITS-1:0] mmag0_reg [3];
    logic [WORD_BITS-1:0] bmag0_reg [3];
    side_t               side0;
    logic signed [WORD_BITS-1:0] mom_in [3];

    always_comb
    begin
        mom_in[0]      = cons.data.cons_mom_x;
        mom_in[1]      = cons.data.cons_mom_y;
        mom_in[2]      = cons.data.cons_mom_z;
        side0.rho      = cons.data.cons_density;
        side0.rho_pos  = !cons.data.cons_density[WORD_BITS-1] && (cons.data.cons_density != '0);
        side0.energy   = cons.data.cons_energy;
        // hydro mode: field is zero everywhere downstream
        side0.bx       = mhd_mode_reg ? cons.data.cons_bx : '0;
        side0.by       = mhd_mode_reg ? cons.data.cons_by : '0;
        side0.bz       = mhd_mode_reg ? cons.data.cons_bz : '0;
        for (int k = 0; k < 3; k++)
        begin
            side0.mom_neg[k] = mom_in[k][WORD_BITS-1];
            side0.mom_nz[k]  = (mom_in[k] != '0);
        end
        side0.interior = cons.data.is_interior;
        side0.mag_e    = '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                mmag0_reg[k] <= mag_word(mom_in[k]);
            end
            bmag0_reg[0] <= mag_word(side0.bx);
            bmag0_reg[1] <= mag_word(side0.by);
            bmag0_reg[2] <= mag_word(side0.bz);
        end
    end

    // ---------------- stage 1: squares ----------------
    logic [2*WORD_BITS-1:0] msq1_reg [3];
    logic [2*WORD_BITS-1:0] bsq1_reg [3];
    logic [WORD_BITS-1:0]   mmag1_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                msq1_reg[k]  <= mmag0_reg[k] * mmag0_reg[k];
                bsq1_reg[k]  <= bmag0_reg[k] * bmag0_reg[k];
                mmag1_reg[k] <= mmag0_reg[k];
            end
        end
    end

    // ---------------- stage 2: sums of squares ----------------
    logic [NUM_BITS-1:0]  msq2_reg;
    logic [WORD_BITS-1:0] mmag2_reg [3];
    logic [NUM_BITS-1:0]  bsum;
    side_t                side2;

    assign bsum = bsq1_reg[0] + bsq1_reg[1] + bsq1_reg[2];

    always_comb
    begin
        side2       = side_reg[1];
        // 0.5*|B|^2: drop the fraction bits and halve
        side2.mag_e = QUO_BITS'(bsum >> (FRAC_BITS + 1));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            msq2_reg <= msq1_reg[0] + msq1_reg[1] + msq1_reg[2];
            for (int k = 0; k < 3; k++)
            begin
                mmag2_reg[k] <= mmag1_reg[k];
            end
        end
    end

    // ---------------- stages 3..14: dividers ----------------
    logic [QUO_BITS-1:0] vq [3];
    logic                vovf [3];
    logic [QUO_BITS-1:0] kq;
    logic                kovf;

    for (genvar k = 0; k < 3; k++)
    begin : g_vdiv
        // (|mom| << FRAC_BITS) / rho
        c2p_div u_div (
            .clk (clk),
            .en  (en),
            .num ({16'd0, mmag2_reg[k], 16'd0}),
            .den ({1'b0, side_reg[2].rho}),
            .quo (vq[k]),
            .ovf (vovf[k])
        );
    end

    // |mom|^2 / (2*rho); overflow means kinetic energy of 2^48 or more
    c2p_div u_kdiv (
        .clk (clk),
        .en  (en),
        .num (msq2_reg),
        .den ({side_reg[2].rho, 1'b0}),
        .quo (kq),
        .ovf (kovf)
    );

    // per-cell side data, one entry per stage up to the divider outputs
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side0;
            side_reg[1] <= side_reg[0];
            side_reg[2] <= side2;
            for (int s = 3; s < SIDE_STAGES; s++)
            begin
                side_reg[s] <= side_reg[s-1];
            end
        end
    end

    // ---------------- stage 15: velocities, inner energy ----------------
    side_t                       sd;
    logic signed [WORD_BITS-1:0] vel_next [3];
    logic [QUO_BITS:0]           kin;
    logic signed [INNER_BITS-1:0] inner;
    logic [INNER_BITS-1:0]       imag;
    logic signed [GAMMA_BITS:0]  gm1;

    logic signed [WORD_BITS-1:0] vel_p1_reg [3];
    logic [QUO_BITS-1:0]         mi_p1_reg;
    logic [GAMMA_BITS-1:0]       mg_p1_reg;
    logic                        neg_p1_reg;
    side_t                       side_p1_reg;

    assign sd = side_reg[SIDE_STAGES-1];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (!sd.rho_pos)
            begin
                // density not positive: velocity saturates by momentum sign
                vel_next[k] = !sd.mom_nz[k] ? '0 : (sd.mom_neg[k] ? WMIN : WMAX);
            end
            else
            begin
                vel_next[k] = sat_word(sd.mom_neg[k], vovf[k] ? '1 : 51'(vq[k]));
            end
        end
        kin   = kovf ? {1'b1, {QUO_BITS{1'b0}}} : {1'b0, kq};
        inner = INNER_BITS'(sd.energy) - $signed(INNER_BITS'(kin))
              - $signed(INNER_BITS'(sd.mag_e));
        imag  = inner[INNER_BITS-1] ? INNER_BITS'(-inner) : INNER_BITS'(inner);
        gm1   = $signed({1'b0, gamma_q_reg}) - $signed((GAMMA_BITS+1)'(1 << FRAC_BITS));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                vel_p1_reg[k] <= vel_next[k];
            end
            // anything from 2^47 on saturates once multiplied by a nonzero gamma-1
            mi_p1_reg   <= (imag >= INNER_BITS'(1) << (QUO_BITS - 1))
                         ? {1'b1, {(QUO_BITS-1){1'b0}}} : QUO_BITS'(imag);
            mg_p1_reg   <= gm1[GAMMA_BITS] ? GAMMA_BITS'(-gm1) : GAMMA_BITS'(gm1);
            neg_p1_reg  <= inner[INNER_BITS-1] ^ gm1[GAMMA_BITS];
            side_p1_reg <= sd;
        end
    end

    // ---------------- stage 16: partial products ----------------
    logic [PRODH+GAMMA_BITS-1:0] plo_reg;
    logic [PRODH+GAMMA_BITS-1:0] phi_reg;
    logic                        neg_p2_reg;
    logic signed [WORD_BITS-1:0] vel_p2_reg [3];
    side_t                       side_p2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            plo_reg     <= mi_p1_reg[PRODH-1:0] * mg_p1_reg;
            phi_reg     <= mi_p1_reg[QUO_BITS-1:PRODH] * mg_p1_reg;
            neg_p2_reg  <= neg_p1_reg;
            for (int k = 0; k < 3; k++)
            begin
                vel_p2_reg[k] <= vel_p1_reg[k];
            end
            side_p2_reg <= side_p1_reg;
        end
    end

    // ---------------- stage 17: pressure, status, output word ----------------
    logic [PROD_BITS-1:0]        prod;
    logic signed [WORD_BITS-1:0] pres;
    prim_t                       prim_next;
    prim_t                       prim_reg;

    always_comb
    begin
        prod = PROD_BITS'(plo_reg) + (PROD_BITS'(phi_reg) << PRODH);
        pres = sat_word(neg_p2_reg, 51'(prod >> FRAC_BITS));

        prim_next.prim_density = side_p2_reg.rho;
        prim_next.prim_vel_x   = vel_p2_reg[0];
        prim_next.prim_vel_y   = vel_p2_reg[1];
        prim_next.prim_vel_z   = vel_p2_reg[2];
        prim_next.prim_bx      = side_p2_reg.bx;
        prim_next.prim_by      = side_p2_reg.by;
        prim_next.prim_bz      = side_p2_reg.bz;
        priority if (!side_p2_reg.rho_pos)
        begin
            prim_next.prim_pressure = '0;
            prim_next.status        = ST_BAD_DENSITY;
        end
        else if (pres[WORD_BITS-1] && side_p2_reg.interior)
        begin
            prim_next.prim_pressure = pres;
            prim_next.status        = ST_NEG_PRESSURE;
        end
        else
        begin
            prim_next.prim_pressure = pres;
            prim_next.status        = ST_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prim_reg <= prim_next;
        end
    end

    assign prim.data = prim_reg;

endmodule : conserved_to_primitive_mhd
`default_nettype wire
